@@ sv/lfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Lyapunov fractal pixel block.
// Used by lfp_div and lyapunov_fractal_pixel; depends on nothing.
package lfp_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 28;
    localparam int LOG_FRAC  = 16;
    localparam int LOG_NORM  = 30;
    localparam logic [FRAC_BITS:0] ONE_FIX  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [30:0]        RATE_MAX = 31'h4000_0000;
    localparam logic [15:0]        LN2_Q16  = 16'd45426;

    // Divider sizes
    localparam int NUM_W = 40;
    localparam int DEN_W = 17;

    // Register indexes
    localparam logic [2:0] CFG_MAX_ITER = 3'd0;
    localparam logic [2:0] CFG_PAT_LEN  = 3'd1;
    localparam logic [2:0] CFG_PAT_BITS = 3'd2;
    localparam logic [2:0] CFG_EXP_FLR  = 3'd3;
    localparam logic [2:0] CFG_EXP_CEIL = 3'd4;

    // Register reset values
    localparam logic [9:0]  RST_MAX_ITER = 10'd75;
    localparam logic [4:0]  RST_PAT_LEN  = 5'd2;
    localparam logic [15:0] RST_PAT_BITS = 16'd1;
    localparam logic [15:0] RST_EXP_FLR  = 16'hD733;
    localparam logic [14:0] RST_EXP_CEIL = 15'd1622;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAP1, ST_MAP2, ST_MAP3, ST_D1, ST_D2, ST_NORM, ST_SQ1, ST_SQ2,
        ST_F1, ST_F2, ST_F3, ST_DGO, ST_DWAIT, ST_QQ1, ST_QQ2,
        ST_CB1, ST_CB2, ST_CB3, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DK_LAMBDA, DK_RED, DK_RATIO
    } t_div_kind;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

endpackage

@@ sv/lfp_mul.sv @@
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing.
module lfp_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // Register the product; it is read in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ sv/lfp_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lfp_pkg.
module lfp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfp_pkg::t_div_req           i_req,
    output logic [lfp_pkg::NUM_W-1:0]   o_quo,
    output logic                        o_done
);

    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  r_cnt;
    logic [lfp_pkg::NUM_W-1:0]   r_quo;
    logic [lfp_pkg::DEN_W-1:0]   r_rem;
    logic [lfp_pkg::DEN_W-1:0]   r_den;
    logic [lfp_pkg::DEN_W:0]     trial;
    logic                        fits;

    // Shift in the next dividend bit and test against the divisor
    always_comb begin
        trial = {r_rem, r_quo[lfp_pkg::NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(lfp_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[lfp_pkg::NUM_W-2:0], fits};
            r_rem <= fits ? lfp_pkg::DEN_W'(trial - {1'b0, r_den})
                          : trial[lfp_pkg::DEN_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

@@ sv/lyapunov_fractal_pixel.sv @@
`timescale 1ns / 1ps
// Lyapunov fractal pixel: maps a rate pair (a, b) to an RGB colour.
// Depends on lfp_pkg, lfp_mul and lfp_div.
//
// Usage: the input channel takes one beat of rate_a/rate_b (Q3.28, values
// above 4.0 clamp to 4.0). o_in_stall is high while a pixel is in work, so
// one pixel is processed at a time. The output channel carries one beat of
// red/green/blue per pixel from an output register; the next pixel may be
// taken while that beat still waits on i_out_stall.
// Sequence: a warm-up step runs the map (MAP1..MAP3); a counted step runs
// the map and log factor (MAP1..MAP3, D1, D2), then normalization and log2
// squaring; a step with a zero factor skips the log. The finish scales the
// sum and runs a division, plus, for red, another division unless the
// ceiling is zero, or for green/blue a division and two 16-bit cube roots.
// All work runs through one shared registered multiplier and one serial
// divider under the sequencer below.
// Reset: sequencer idle, no output beat, registers to defaults. Config is
// written through i_cfg_wr_en/i_cfg_index/i_cfg_data; the user must write
// it only while idle, since the block itself does not enforce that.
// A stalled output holds its beat; a finished pixel waits in the last
// state until the output register is free.
module lyapunov_fractal_pixel #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_rate_a,
    input  logic [30:0] i_rate_b,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam int FB = lfp_pkg::FRAC_BITS;
    localparam int SW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW = 10 + LW;

    // 255 * (1 - v / 65536), truncated
    function automatic logic [7:0] scale_inv(input logic [15:0] v);
        logic [16:0] w;
        logic [24:0] s;
        begin
            w = 17'h10000 - {1'b0, v};
            s = {w, 8'b0} - {8'b0, w};
            return s[23:16];
        end
    endfunction

    // Configuration registers
    logic [9:0]  r_cfg_iter;
    logic [4:0]  r_cfg_len;
    logic [15:0] r_cfg_bits;
    logic [15:0] r_cfg_floor;
    logic [14:0] r_cfg_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_iter  <= lfp_pkg::RST_MAX_ITER;
            r_cfg_len   <= lfp_pkg::RST_PAT_LEN;
            r_cfg_bits  <= lfp_pkg::RST_PAT_BITS;
            r_cfg_floor <= lfp_pkg::RST_EXP_FLR;
            r_cfg_ceil  <= lfp_pkg::RST_EXP_CEIL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lfp_pkg::CFG_MAX_ITER: r_cfg_iter  <= i_cfg_data[9:0];
                lfp_pkg::CFG_PAT_LEN:  r_cfg_len   <= i_cfg_data[4:0];
                lfp_pkg::CFG_PAT_BITS: r_cfg_bits  <= i_cfg_data;
                lfp_pkg::CFG_EXP_FLR:  r_cfg_floor <= i_cfg_data;
                lfp_pkg::CFG_EXP_CEIL: r_cfg_ceil  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Effective pass count and pattern length
    logic [9:0]  iters;
    logic [7:0]  len8;
    logic [LW-1:0] len;
    logic [16:0] floor_mag;

    always_comb begin
        iters = (r_cfg_iter == 10'd0) ? 10'd1 : r_cfg_iter;
        len8  = (r_cfg_len == 5'd0) ? 8'd1 : 8'(r_cfg_len);
        if (len8 > 8'(MAX_PATTERN_LEN)) len8 = 8'(MAX_PATTERN_LEN);
        len = LW'(len8);
        floor_mag = r_cfg_floor[15] ? 17'(17'h10000 - {1'b0, r_cfg_floor}) : 17'd1;
    end

    // State and datapath registers
    lfp_pkg::t_state    r_state, n_state;
    lfp_pkg::t_div_kind r_dkind, n_dkind;
    logic [30:0]  r_ra, n_ra, r_rb, n_rb;
    logic [FB:0]  r_x, n_x;
    logic [SW-1:0] r_step, n_step;
    logic [9:0]   r_pass, n_pass;
    logic         r_warm, n_warm;
    logic         r_zero, n_zero;
    logic signed [39:0] r_total, n_total;
    logic [30:0]  r_m, n_m;
    logic [4:0]   r_lp, n_lp;
    logic [3:0]   r_lcnt, n_lcnt;
    logic [15:0]  r_frac, n_frac;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [51:0]  r_acc, n_acc;
    logic [39:0]  r_dnum, n_dnum;
    logic [16:0]  r_dden, n_dden;
    logic [15:0]  r_q, n_q;
    logic [47:0]  r_v2, n_v2;
    logic         r_rsel, n_rsel;
    logic [15:0]  r_res, n_res;
    logic [3:0]   r_bit, n_bit;
    logic [15:0]  r_c, n_c;
    logic [7:0]   r_pr, n_pr, r_pg, n_pg, r_pb, n_pb;
    logic         r_ovalid, n_ovalid;
    logic [7:0]   r_ored, n_ored, r_ogrn, n_ogrn, r_oblu, n_oblu;

    // Shared units
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    lfp_pkg::t_div_req div_req;
    logic [lfp_pkg::NUM_W-1:0] quo;
    logic         div_done;

    lfp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    lfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // Step helpers
    logic [7:0]   step8;
    logic         sel_b;
    logic [30:0]  cur_r;
    logic         last_step, last_pass;
    logic [FB+1:0] x2;
    logic [FB:0]  fac;
    logic [30:0]  dval;
    logic [31:0]  sq;
    logic [5:0]   lexp;
    logic [39:0]  tot_mag;
    logic         in_acc;
    logic         out_free;
    logic [15:0]  cand;
    logic [47:0]  cb_lim;
    logic [15:0]  res_new;
    logic [27:0]  lam255;

    always_comb begin
        step8     = 8'(r_step);
        sel_b     = (step8 < 8'd16) && r_cfg_bits[step8[3:0]];
        cur_r     = sel_b ? r_rb : r_ra;
        last_step = (LW'(r_step) + LW'(1)) == len;
        last_pass = (r_pass + 10'd1) == iters;
        x2        = {r_x, 1'b0};
        fac       = (x2 >= (FB + 2)'(lfp_pkg::ONE_FIX)) ?
                    (FB + 1)'(x2 - (FB + 2)'(lfp_pkg::ONE_FIX)) :
                    (FB + 1)'((FB + 2)'(lfp_pkg::ONE_FIX) - x2);
        dval      = prod[FB+30:FB];
        sq        = prod[lfp_pkg::LOG_NORM+31:lfp_pkg::LOG_NORM];
        lexp      = {1'b0, r_lp} - 6'(FB);
        tot_mag   = r_total[39] ? 40'(-r_total) : r_total;
        in_acc    = i_in_valid && !o_in_stall;
        out_free  = !r_ovalid || !i_out_stall;
        cand      = r_res | (16'd1 << r_bit);
        cb_lim    = r_rsel ? r_v2 : {r_q, 32'b0};
        res_new   = (prod[47:0] <= cb_lim) ? cand : r_res;
        lam255    = {quo[19:0], 8'b0} - {8'b0, quo[19:0]};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfp_pkg::ST_IDLE:  if (i_in_valid) n_state = lfp_pkg::ST_MAP1;
            lfp_pkg::ST_MAP1:  n_state = lfp_pkg::ST_MAP2;
            lfp_pkg::ST_MAP2:  n_state = lfp_pkg::ST_MAP3;
            lfp_pkg::ST_MAP3: begin
                if (!r_warm && last_step && last_pass) n_state = lfp_pkg::ST_F1;
                else if (r_warm && !last_step)         n_state = lfp_pkg::ST_MAP1;
                else                                   n_state = lfp_pkg::ST_D1;
            end
            lfp_pkg::ST_D1:    n_state = lfp_pkg::ST_D2;
            lfp_pkg::ST_D2:    n_state = (dval == '0) ? lfp_pkg::ST_MAP1 : lfp_pkg::ST_NORM;
            lfp_pkg::ST_NORM:  if (r_m[30]) n_state = lfp_pkg::ST_SQ1;
            lfp_pkg::ST_SQ1:   n_state = lfp_pkg::ST_SQ2;
            lfp_pkg::ST_SQ2:   n_state = (r_lcnt == 4'd15) ? lfp_pkg::ST_MAP1 : lfp_pkg::ST_SQ1;
            lfp_pkg::ST_F1:    n_state = lfp_pkg::ST_F2;
            lfp_pkg::ST_F2:    n_state = lfp_pkg::ST_F3;
            lfp_pkg::ST_F3:    n_state = lfp_pkg::ST_DGO;
            lfp_pkg::ST_DGO:   n_state = lfp_pkg::ST_DWAIT;
            lfp_pkg::ST_DWAIT: begin
                if (div_done) begin
                    unique case (r_dkind)
                        lfp_pkg::DK_LAMBDA: begin
                            if (r_zero)
                                n_state = lfp_pkg::ST_OUT;
                            else if (!r_total[39] && quo != '0)
                                n_state = (r_cfg_ceil == '0) ? lfp_pkg::ST_OUT
                                                             : lfp_pkg::ST_DGO;
                            else
                                n_state = (17'(quo[19:0]) >= floor_mag) ? lfp_pkg::ST_OUT
                                                                        : lfp_pkg::ST_DGO;
                        end
                        lfp_pkg::DK_RED:   n_state = lfp_pkg::ST_OUT;
                        lfp_pkg::DK_RATIO: n_state = lfp_pkg::ST_QQ1;
                        default:           n_state = lfp_pkg::ST_OUT;
                    endcase
                end
            end
            lfp_pkg::ST_QQ1:   n_state = lfp_pkg::ST_QQ2;
            lfp_pkg::ST_QQ2:   n_state = lfp_pkg::ST_CB1;
            lfp_pkg::ST_CB1:   n_state = lfp_pkg::ST_CB2;
            lfp_pkg::ST_CB2:   n_state = lfp_pkg::ST_CB3;
            lfp_pkg::ST_CB3:   n_state = (r_bit == 4'd0 && r_rsel) ? lfp_pkg::ST_OUT
                                                                   : lfp_pkg::ST_CB1;
            lfp_pkg::ST_OUT:   if (out_free) n_state = lfp_pkg::ST_IDLE;
            default:           n_state = lfp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit controls per state
    always_comb begin
        n_ra = r_ra;   n_rb = r_rb;   n_x = r_x;     n_step = r_step;
        n_pass = r_pass; n_warm = r_warm; n_zero = r_zero; n_total = r_total;
        n_m = r_m;     n_lp = r_lp;   n_lcnt = r_lcnt; n_frac = r_frac;
        n_cnt = r_cnt; n_acc = r_acc; n_dnum = r_dnum; n_dden = r_dden;
        n_dkind = r_dkind; n_q = r_q; n_v2 = r_v2; n_rsel = r_rsel;
        n_res = r_res; n_bit = r_bit; n_c = r_c;
        n_pr = r_pr;   n_pg = r_pg;   n_pb = r_pb;
        n_ovalid = r_ovalid && i_out_stall;
        n_ored = r_ored; n_ogrn = r_ogrn; n_oblu = r_oblu;
        mul_a = '0;    mul_b = '0;
        div_req.start = 1'b0;
        div_req.num   = r_dnum;
        div_req.den   = r_dden;
        unique case (r_state)
            lfp_pkg::ST_IDLE: begin
                // Take a beat and seed the orbit
                if (in_acc) begin
                    n_ra    = (i_rate_a > lfp_pkg::RATE_MAX) ? lfp_pkg::RATE_MAX : i_rate_a;
                    n_rb    = (i_rate_b > lfp_pkg::RATE_MAX) ? lfp_pkg::RATE_MAX : i_rate_b;
                    n_x     = lfp_pkg::ONE_FIX >> 1;
                    n_step  = '0;
                    n_pass  = '0;
                    n_warm  = 1'b1;
                    n_zero  = 1'b0;
                    n_total = '0;
                end
            end
            lfp_pkg::ST_MAP1: begin
                mul_a = 32'(r_x);
                mul_b = 32'(lfp_pkg::ONE_FIX - r_x);
            end
            lfp_pkg::ST_MAP2: begin
                mul_a = 32'(cur_r);
                mul_b = 32'(prod[FB+26:FB]);
            end
            lfp_pkg::ST_MAP3: begin
                // Update x and advance the pattern position
                n_x = (prod[FB+29:FB] > 30'(lfp_pkg::ONE_FIX)) ? lfp_pkg::ONE_FIX
                                                                : prod[FB+FB:FB];
                if (last_step) begin
                    n_step = '0;
                    n_warm = 1'b0;
                    if (!r_warm) n_pass = r_pass + 10'd1;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            lfp_pkg::ST_D1: begin
                mul_a = 32'(cur_r);
                mul_b = 32'(fac);
            end
            lfp_pkg::ST_D2: begin
                if (dval == '0) n_zero = 1'b1;
                n_m    = dval;
                n_lp   = 5'(lfp_pkg::LOG_NORM);
                n_lcnt = '0;
                n_frac = '0;
            end
            lfp_pkg::ST_NORM: begin
                // Normalize the top bit to position 30
                if (r_m[30:23] == 8'd0) begin
                    n_m  = {r_m[22:0], 8'b0};
                    n_lp = r_lp - 5'd8;
                end else if (!r_m[30]) begin
                    n_m  = {r_m[29:0], 1'b0};
                    n_lp = r_lp - 5'd1;
                end
            end
            lfp_pkg::ST_SQ1: begin
                mul_a = 32'(r_m);
                mul_b = 32'(r_m);
            end
            lfp_pkg::ST_SQ2: begin
                // One fraction bit of log2 per squaring
                n_m    = sq[31] ? sq[31:1] : sq[30:0];
                n_frac = {r_frac[lfp_pkg::LOG_FRAC-2:0], sq[31]};
                n_lcnt = r_lcnt + 4'd1;
                if (r_lcnt == 4'd15)
                    n_total = r_total + 40'($signed({lexp, n_frac}));
            end
            lfp_pkg::ST_F1: begin
                n_cnt = CW'(iters) * CW'(len);
                mul_a = tot_mag[31:0];
                mul_b = 32'(lfp_pkg::LN2_Q16);
            end
            lfp_pkg::ST_F2: begin
                n_acc = prod[51:0];
                mul_a = 32'(tot_mag[39:32]);
                mul_b = 32'(lfp_pkg::LN2_Q16);
            end
            lfp_pkg::ST_F3: begin
                n_acc   = r_acc + {prod[19:0], 32'b0};
                n_dnum  = 40'(n_acc[51:20]);
                n_dden  = 17'(r_cnt);
                n_dkind = lfp_pkg::DK_LAMBDA;
            end
            lfp_pkg::ST_DGO: begin
                div_req.start = 1'b1;
            end
            lfp_pkg::ST_DWAIT: begin
                if (div_done) begin
                    unique case (r_dkind)
                        lfp_pkg::DK_LAMBDA: begin
                            n_pr = '0; n_pg = '0; n_pb = '0;
                            if (r_zero) begin
                                // Minus infinity: black
                            end else if (!r_total[39] && quo != '0) begin
                                if (r_cfg_ceil == '0) begin
                                    n_pr = 8'd255;
                                end else begin
                                    n_dnum  = 40'(lam255);
                                    n_dden  = 17'(r_cfg_ceil);
                                    n_dkind = lfp_pkg::DK_RED;
                                end
                            end else if (17'(quo[19:0]) < floor_mag) begin
                                n_dnum  = 40'({quo[19:0], 16'b0});
                                n_dden  = floor_mag;
                                n_dkind = lfp_pkg::DK_RATIO;
                            end
                        end
                        lfp_pkg::DK_RED: begin
                            n_pr = (quo[39:8] != '0) ? 8'd255 : quo[7:0];
                        end
                        lfp_pkg::DK_RATIO: begin
                            n_q = quo[15:0];
                        end
                        default: ;
                    endcase
                end
            end
            lfp_pkg::ST_QQ1: begin
                mul_a = 32'(r_q);
                mul_b = 32'(r_q);
            end
            lfp_pkg::ST_QQ2: begin
                n_v2   = {prod[31:0], 16'b0};
                n_rsel = 1'b0;
                n_res  = '0;
                n_bit  = 4'd15;
            end
            lfp_pkg::ST_CB1: begin
                mul_a = 32'(cand);
                mul_b = 32'(cand);
            end
            lfp_pkg::ST_CB2: begin
                mul_a = prod[31:0];
                mul_b = 32'(cand);
            end
            lfp_pkg::ST_CB3: begin
                // Keep the trial bit if its cube still fits
                n_res = res_new;
                n_bit = r_bit - 4'd1;
                if (r_bit == 4'd0) begin
                    if (!r_rsel) begin
                        n_c    = res_new;
                        n_rsel = 1'b1;
                        n_res  = '0;
                        n_bit  = 4'd15;
                    end else begin
                        n_pg = scale_inv(r_c);
                        n_pb = scale_inv(res_new);
                    end
                end
            end
            lfp_pkg::ST_OUT: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ored   = r_pr;
                    n_ogrn   = r_pg;
                    n_oblu   = r_pb;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfp_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;     r_rb <= n_rb;     r_x <= n_x;       r_step <= n_step;
        r_pass <= n_pass; r_warm <= n_warm; r_zero <= n_zero; r_total <= n_total;
        r_m <= n_m;       r_lp <= n_lp;     r_lcnt <= n_lcnt; r_frac <= n_frac;
        r_cnt <= n_cnt;   r_acc <= n_acc;   r_dnum <= n_dnum; r_dden <= n_dden;
        r_dkind <= n_dkind; r_q <= n_q;     r_v2 <= n_v2;     r_rsel <= n_rsel;
        r_res <= n_res;   r_bit <= n_bit;   r_c <= n_c;
        r_pr <= n_pr;     r_pg <= n_pg;     r_pb <= n_pb;
        r_ored <= n_ored; r_ogrn <= n_ogrn; r_oblu <= n_oblu;
    end

    assign o_in_stall  = (r_state != lfp_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_red       = r_ored;
    assign o_green     = r_ogrn;
    assign o_blue      = r_oblu;

    // A new output beat only comes from the final state
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == lfp_pkg::ST_OUT)
        else $error("output beat raised outside the final state");

    // Red excludes green and blue
    a_red_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ored != 8'd0) |-> (r_ogrn == 8'd0 && r_oblu == 8'd0))
        else $error("red beat carries green or blue");

    // Squaring starts from a normalized mantissa
    a_log_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfp_pkg::ST_SQ1) |-> r_m[30])
        else $error("log mantissa not normalized");

    // The orbit never leaves the unit interval
    a_x_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfp_pkg::ST_MAP1 || r_state == lfp_pkg::ST_D1) |->
        r_x <= lfp_pkg::ONE_FIX)
        else $error("x above 1.0");

endmodule
